### rtl/srarq_pkg.sv
// Shared types and constants of the selective-repeat ARQ controller.
`default_nettype none
package srarq_pkg;

  // Sequence numbers count modulo SEQ_MAX + 1 = 16, so they wrap naturally in SEQ_W bits.
  localparam int SEQ_W        = 4;
  localparam int SEQ_MAX      = 15;
  localparam int SLOT_W       = 3;
  localparam int WINDOW_SLOTS = 8;
  localparam int STEP_W       = 5;
  localparam int CNT_W        = 5;
  // Non-gate commands kept per event; the gate item always takes the last place.
  localparam int MAX_CMDS     = 31;
  localparam int BC_MAX       = 15;

  localparam logic [2:0] OP_NET_READY  = 3'd0;
  localparam logic [2:0] OP_PHYS_READY = 3'd1;
  localparam logic [2:0] OP_FRAME      = 3'd2;
  localparam logic [2:0] OP_DATA_TMO   = 3'd3;
  localparam logic [2:0] OP_ACK_TMO    = 3'd4;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ACK  = 2'd1;
  localparam logic [1:0] KIND_NAK  = 2'd2;

  typedef enum logic [2:0] {
    CMD_SEND     = 3'd0,
    CMD_DELIVER  = 3'd1,
    CMD_START_DT = 3'd2,
    CMD_STOP_DT  = 3'd3,
    CMD_START_AT = 3'd4,
    CMD_STOP_AT  = 3'd5,
    CMD_GATE     = 3'd6
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [1:0]        send_kind;
    logic [SEQ_W-1:0]  seq_number;
    logic [SEQ_W-1:0]  ack_number;
    logic [SLOT_W-1:0] slot;
    logic              network_enable;
    logic              last;
  } res_t;

  // Operands of the circular window compare: is b in [a, c) modulo the sequence space.
  typedef struct packed {
    logic [SEQ_W-1:0] a;
    logic [SEQ_W-1:0] b;
    logic [SEQ_W-1:0] c;
  } win_req_t;

endpackage
`default_nettype wire

### rtl/selective_repeat_arq_controller_top.sv
// Top level of the selective-repeat ARQ controller.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------------
//  in_      | in_valid/in_stall  | operation, frame_good, rx_kind, rx_seq,
//           |                    | frame_ack, timeout_seq
//  out_     | out_valid/out_stall| command, send_kind, seq_number, ack_number, slot,
//           |                    | network_enable, last
//
// An event is taken, then its commands are issued in turn, with a frame decode state and a
// receive window check state where needed, and a closing gate step ends each event. The
// sequencer issues at most one command a cycle through the output register unless the
// output stalls, and the shared window compare unit serves one check a cycle.
// Reset (rst_n low, synchronous) restores the window edges, clears the arrived bits
// and empties the output register. A stalled output holds the sequencer in any state that loads it.
`default_nettype none
module selective_repeat_arq_controller_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_operation,
  input  logic                        in_frame_good,
  input  logic [1:0]                  in_rx_kind,
  input  logic [srarq_pkg::SEQ_W-1:0] in_rx_seq,
  input  logic [srarq_pkg::SEQ_W-1:0] in_frame_ack,
  input  logic [srarq_pkg::SEQ_W-1:0] in_timeout_seq,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_command,
  output logic [1:0]                  out_send_kind,
  output logic [srarq_pkg::SEQ_W-1:0] out_seq_number,
  output logic [srarq_pkg::SEQ_W-1:0] out_ack_number,
  output logic [srarq_pkg::SLOT_W-1:0] out_slot,
  output logic                        out_network_enable,
  output logic                        out_last
);

  logic            can_load;
  logic            load;
  srarq_pkg::res_t res;
  srarq_pkg::res_t out_res;

  srarq_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_frame_good  (in_frame_good),
    .in_rx_kind     (in_rx_kind),
    .in_rx_seq      (in_rx_seq),
    .in_frame_ack   (in_frame_ack),
    .in_timeout_seq (in_timeout_seq),
    .can_load       (can_load),
    .load           (load),
    .res            (res)
  );

  srarq_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res       (res),
    .out_stall (out_stall),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_command        = out_res.command;
  assign out_send_kind      = out_res.send_kind;
  assign out_seq_number     = out_res.seq_number;
  assign out_ack_number     = out_res.ack_number;
  assign out_slot           = out_res.slot;
  assign out_network_enable = out_res.network_enable;
  assign out_last           = out_res.last;

endmodule
`default_nettype wire

### rtl/srarq_win.sv
// Shared circular window compare unit.
`default_nettype none
module srarq_win (
  input  srarq_pkg::win_req_t req,
  output logic                hit
);

  logic ab;
  logic bc;
  logic ca;

  assign ab  = req.a <= req.b;
  assign bc  = req.b < req.c;
  assign ca  = req.c < req.a;
  assign hit = (ab && bc) || (ca && ab) || (bc && ca);

endmodule
`default_nettype wire

### rtl/srarq_out.sv
// Output register of the result channel.
`default_nettype none
module srarq_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  srarq_pkg::res_t   res,
  input  logic              out_stall,
  output logic              can_load,
  output logic              out_valid,
  output srarq_pkg::res_t   out_res
);

  logic            valid_r;
  srarq_pkg::res_t data_r;

  assign can_load  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

endmodule
`default_nettype wire

### rtl/srarq_seq.sv
// Sequencer and link state: at most one command per cycle unless the output stalls.
`default_nettype none
module srarq_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_operation,
  input  logic                          in_frame_good,
  input  logic [1:0]                    in_rx_kind,
  input  logic [srarq_pkg::SEQ_W-1:0]   in_rx_seq,
  input  logic [srarq_pkg::SEQ_W-1:0]   in_frame_ack,
  input  logic [srarq_pkg::SEQ_W-1:0]   in_timeout_seq,
  input  logic                          can_load,
  output logic                          load,
  output srarq_pkg::res_t               res
);

  localparam int SW     = srarq_pkg::SEQ_W;
  localparam int LW     = srarq_pkg::SLOT_W;
  localparam int CNT_W  = srarq_pkg::CNT_W;
  localparam int STEP_W = srarq_pkg::STEP_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEND,
    ST_START_DT,
    ST_STOP_AT,
    ST_FRAME,
    ST_RX_AT,
    ST_RX_CHECK,
    ST_DELIVER,
    ST_DELIVER_AT,
    ST_WALK,
    ST_GATE
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;

  logic                  good_r, good_nxt;
  logic [1:0]            kind_r, kind_nxt;
  logic [SW-1:0]         fseq_r, fseq_nxt;
  logic [SW-1:0]         fack_r, fack_nxt;
  logic [SW-1:0]         ackv_r, ackv_nxt;
  logic [1:0]            snd_kind_r, snd_kind_nxt;
  logic [SW-1:0]         snd_seq_r, snd_seq_nxt;
  logic [SW-1:0]         snd_ack_r, snd_ack_nxt;
  logic [SW-1:0]         swl_r, swl_nxt;
  logic [SW-1:0]         sn_r, sn_nxt;
  logic [SW-1:0]         re_r, re_nxt;
  logic [SW-1:0]         rl_r, rl_nxt;
  logic [SW-1:0]         bc_r, bc_nxt;
  logic [srarq_pkg::WINDOW_SLOTS-1:0] arr_r, arr_nxt;
  logic                  nak_ok_r, nak_ok_nxt;
  logic                  phys_r, phys_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  srarq_pkg::win_req_t win_req;
  logic                win_hit;
  logic                room;
  logic [SW-1:0]       ack_back;

  srarq_win u_win (
    .req (win_req),
    .hit (win_hit)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign room     = cnt_r < CNT_W'(srarq_pkg::MAX_CMDS);
  assign ack_back = re_r - SW'(1);

  always_comb begin
    unique case (state_r)
      ST_FRAME:    win_req = '{a: swl_r, b: fseq_r, c: sn_r};
      ST_RX_CHECK: win_req = '{a: re_r,  b: fseq_r, c: rl_r};
      default:     win_req = '{a: swl_r, b: ackv_r, c: sn_r};
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    good_nxt     = good_r;
    kind_nxt     = kind_r;
    fseq_nxt     = fseq_r;
    fack_nxt     = fack_r;
    ackv_nxt     = ackv_r;
    snd_kind_nxt = snd_kind_r;
    snd_seq_nxt  = snd_seq_r;
    snd_ack_nxt  = snd_ack_r;
    swl_nxt      = swl_r;
    sn_nxt       = sn_r;
    re_nxt       = re_r;
    rl_nxt       = rl_r;
    bc_nxt       = bc_r;
    arr_nxt      = arr_r;
    nak_ok_nxt   = nak_ok_r;
    phys_nxt     = phys_r;
    step_nxt     = step_r;
    cnt_nxt      = cnt_r;
    load         = 1'b0;
    res          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          good_nxt = in_frame_good;
          kind_nxt = in_rx_kind;
          fseq_nxt = in_rx_seq;
          fack_nxt = in_frame_ack;
          cnt_nxt  = '0;
          ret_nxt  = ST_GATE;
          unique case (in_operation)
            srarq_pkg::OP_NET_READY: begin
              if (bc_r < SW'(srarq_pkg::BC_MAX)) begin
                bc_nxt = bc_r + SW'(1);
              end
              snd_kind_nxt = srarq_pkg::KIND_DATA;
              snd_seq_nxt  = sn_r;
              snd_ack_nxt  = ack_back;
              sn_nxt       = sn_r + SW'(1);
              state_nxt    = ST_SEND;
            end
            srarq_pkg::OP_PHYS_READY: begin
              phys_nxt  = 1'b1;
              state_nxt = ST_GATE;
            end
            srarq_pkg::OP_FRAME: begin
              state_nxt = ST_FRAME;
            end
            srarq_pkg::OP_DATA_TMO: begin
              snd_kind_nxt = srarq_pkg::KIND_DATA;
              snd_seq_nxt  = in_timeout_seq;
              snd_ack_nxt  = ack_back;
              state_nxt    = ST_SEND;
            end
            srarq_pkg::OP_ACK_TMO: begin
              snd_kind_nxt = srarq_pkg::KIND_ACK;
              snd_seq_nxt  = ack_back;
              snd_ack_nxt  = '0;
              state_nxt    = ST_SEND;
            end
            default: begin
              state_nxt = ST_GATE;
            end
          endcase
        end
      end

      ST_SEND: begin
        if (can_load) begin
          load           = room;
          cnt_nxt        = cnt_r + CNT_W'(room);
          res.command    = srarq_pkg::CMD_SEND;
          res.send_kind  = snd_kind_r;
          res.seq_number = snd_seq_r;
          res.ack_number = snd_ack_r;
          res.slot       = (snd_kind_r == srarq_pkg::KIND_DATA) ? snd_seq_r[LW-1:0] : '0;
          phys_nxt       = 1'b0;
          if (snd_kind_r == srarq_pkg::KIND_DATA) begin
            state_nxt = ST_START_DT;
          end else begin
            if (snd_kind_r == srarq_pkg::KIND_NAK) begin
              nak_ok_nxt = 1'b0;
            end
            state_nxt = ST_STOP_AT;
          end
        end
      end

      ST_START_DT: begin
        if (can_load) begin
          load           = room;
          cnt_nxt        = cnt_r + CNT_W'(room);
          res.command    = srarq_pkg::CMD_START_DT;
          res.seq_number = snd_seq_r;
          state_nxt      = ST_STOP_AT;
        end
      end

      ST_STOP_AT: begin
        if (can_load) begin
          load        = room;
          cnt_nxt     = cnt_r + CNT_W'(room);
          res.command = srarq_pkg::CMD_STOP_AT;
          state_nxt   = ret_r;
        end
      end

      ST_FRAME: begin
        step_nxt = '0;
        ackv_nxt = fack_r;
        if (!good_r) begin
          if (nak_ok_r) begin
            snd_kind_nxt = srarq_pkg::KIND_NAK;
            snd_seq_nxt  = re_r;
            snd_ack_nxt  = '0;
            ret_nxt      = ST_GATE;
            state_nxt    = ST_SEND;
          end else begin
            state_nxt = ST_GATE;
          end
        end else begin
          unique case (kind_r)
            srarq_pkg::KIND_DATA: begin
              if (fseq_r != re_r && nak_ok_r) begin
                snd_kind_nxt = srarq_pkg::KIND_NAK;
                snd_seq_nxt  = re_r;
                snd_ack_nxt  = '0;
                ret_nxt      = ST_RX_CHECK;
                state_nxt    = ST_SEND;
              end else begin
                state_nxt = ST_RX_AT;
              end
            end
            srarq_pkg::KIND_NAK: begin
              // A NAK resends the named frame only while it is still outstanding.
              if (win_hit) begin
                snd_kind_nxt = srarq_pkg::KIND_DATA;
                snd_seq_nxt  = fseq_r;
                snd_ack_nxt  = ack_back;
                ret_nxt      = ST_GATE;
                state_nxt    = ST_SEND;
              end else begin
                state_nxt = ST_GATE;
              end
            end
            srarq_pkg::KIND_ACK: begin
              ackv_nxt  = fseq_r;
              state_nxt = ST_WALK;
            end
            default: begin
              state_nxt = ST_WALK;
            end
          endcase
        end
      end

      ST_RX_AT: begin
        if (can_load) begin
          load        = room;
          cnt_nxt     = cnt_r + CNT_W'(room);
          res.command = srarq_pkg::CMD_START_AT;
          state_nxt   = ST_RX_CHECK;
        end
      end

      ST_RX_CHECK: begin
        step_nxt = '0;
        if (win_hit && !arr_r[fseq_r[LW-1:0]]) begin
          arr_nxt[fseq_r[LW-1:0]] = 1'b1;
          state_nxt = ST_DELIVER;
        end else begin
          state_nxt = ST_WALK;
        end
      end

      ST_DELIVER: begin
        if (can_load) begin
          if (step_r < STEP_W'(srarq_pkg::WINDOW_SLOTS) && arr_r[re_r[LW-1:0]]) begin
            load                  = room;
            cnt_nxt               = cnt_r + CNT_W'(room);
            res.command           = srarq_pkg::CMD_DELIVER;
            res.slot              = re_r[LW-1:0];
            nak_ok_nxt            = 1'b1;
            arr_nxt[re_r[LW-1:0]] = 1'b0;
            re_nxt                = re_r + SW'(1);
            rl_nxt                = rl_r + SW'(1);
            step_nxt              = step_r + STEP_W'(1);
            state_nxt             = ST_DELIVER_AT;
          end else begin
            step_nxt  = '0;
            state_nxt = ST_WALK;
          end
        end
      end

      ST_DELIVER_AT: begin
        if (can_load) begin
          load        = room;
          cnt_nxt     = cnt_r + CNT_W'(room);
          res.command = srarq_pkg::CMD_START_AT;
          state_nxt   = ST_DELIVER;
        end
      end

      ST_WALK: begin
        if (can_load) begin
          // Each step retires the oldest outstanding frame up to the acked number.
          if (step_r <= STEP_W'(srarq_pkg::SEQ_MAX) && win_hit) begin
            if (bc_r != '0) begin
              bc_nxt = bc_r - SW'(1);
            end
            load           = room;
            cnt_nxt        = cnt_r + CNT_W'(room);
            res.command    = srarq_pkg::CMD_STOP_DT;
            res.seq_number = swl_r;
            swl_nxt        = swl_r + SW'(1);
            step_nxt       = step_r + STEP_W'(1);
          end else begin
            state_nxt = ST_GATE;
          end
        end
      end

      ST_GATE: begin
        if (can_load) begin
          load               = 1'b1;
          res.command        = srarq_pkg::CMD_GATE;
          res.network_enable = (bc_r < SW'(srarq_pkg::WINDOW_SLOTS)) && phys_r;
          res.last           = 1'b1;
          state_nxt          = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ret_r    <= ST_GATE;
      swl_r    <= '0;
      sn_r     <= '0;
      re_r     <= '0;
      rl_r     <= SW'(srarq_pkg::WINDOW_SLOTS);
      bc_r     <= '0;
      arr_r    <= '0;
      nak_ok_r <= 1'b1;
      phys_r   <= 1'b0;
      step_r   <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      swl_r    <= swl_nxt;
      sn_r     <= sn_nxt;
      re_r     <= re_nxt;
      rl_r     <= rl_nxt;
      bc_r     <= bc_nxt;
      arr_r    <= arr_nxt;
      nak_ok_r <= nak_ok_nxt;
      phys_r   <= phys_nxt;
      step_r   <= step_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    good_r     <= good_nxt;
    kind_r     <= kind_nxt;
    fseq_r     <= fseq_nxt;
    fack_r     <= fack_nxt;
    ackv_r     <= ackv_nxt;
    snd_kind_r <= snd_kind_nxt;
    snd_seq_r  <= snd_seq_nxt;
    snd_ack_r  <= snd_ack_nxt;
  end

endmodule
`default_nettype wire

### rtl/srarq_chk.sv
// Port-level checks of the ARQ controller and their binding to the top level.
`default_nettype none
module srarq_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [2:0]                  out_command,
  input wire logic [1:0]                  out_send_kind,
  input wire logic [srarq_pkg::SEQ_W-1:0] out_seq_number,
  input wire logic                        out_network_enable,
  input wire logic                        out_last
);

  // Every event ends in a gate item, so the block is busy right after a transfer in.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous event still in progress");

  a_last_is_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_command == srarq_pkg::CMD_GATE)))
    else $error("last flag does not mark the gate item");

  a_enable_on_gate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command != srarq_pkg::CMD_GATE |-> !out_network_enable)
    else $error("network enable set on a non-gate item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_command)
      && $stable(out_seq_number) && $stable(out_send_kind))
    else $error("stalled result changed");

endmodule

bind selective_repeat_arq_controller_top srarq_chk u_chk (.*);
`default_nettype wire

### bench/tb_selective_repeat_arq_controller_top.sv
// Self-checking testbench of the selective-repeat ARQ controller top level.
`timescale 1ns / 100ps
module tb_selective_repeat_arq_controller_top;

  localparam int SW = srarq_pkg::SEQ_W;
  localparam int LW = srarq_pkg::SLOT_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 60;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [2:0]    op;
    logic          good;
    logic [1:0]    kind;
    logic [SW-1:0] fseq;
    logic [SW-1:0] fack;
    logic [SW-1:0] tseq;
  } link_event_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_operation = '0;
  logic in_frame_good = 1'b0;
  logic [1:0] in_rx_kind = '0;
  logic [SW-1:0] in_rx_seq = '0;
  logic [SW-1:0] in_frame_ack = '0;
  logic [SW-1:0] in_timeout_seq = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_command;
  logic [1:0] out_send_kind;
  logic [SW-1:0] out_seq_number;
  logic [SW-1:0] out_ack_number;
  logic [LW-1:0] out_slot;
  logic out_network_enable;
  logic out_last;

  // Mirror of the link state, updated as each event transfer is accepted.
  logic [SW-1:0] snd_low, snd_next, rcv_exp, rcv_lim;
  logic [srarq_pkg::WINDOW_SLOTS-1:0] arrived;
  logic nak_ok, phys_rdy;
  int buf_count;
  int cmds_in_event;

  srarq_pkg::res_t expected_cmds[$];

  int error_count = 0;
  int cmds_checked = 0;
  int events_sent = 0;
  int overflow_events = 0;
  int longest_event = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_cycles = 0;
  int mode_left = 0;
  int stall_phase = 0;
  stall_mode_t stall_mode = STALL_NONE;

  selective_repeat_arq_controller_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_frame_good      (in_frame_good),
    .in_rx_kind         (in_rx_kind),
    .in_rx_seq          (in_rx_seq),
    .in_frame_ack       (in_frame_ack),
    .in_timeout_seq     (in_timeout_seq),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_command        (out_command),
    .out_send_kind      (out_send_kind),
    .out_seq_number     (out_seq_number),
    .out_ack_number     (out_ack_number),
    .out_slot           (out_slot),
    .out_network_enable (out_network_enable),
    .out_last           (out_last)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- prediction

  function automatic logic seq_between(input logic [SW-1:0] a, input logic [SW-1:0] b,
                                       input logic [SW-1:0] c);
    return (a <= b && b < c) || (c < a && a <= b) || (b < c && c < a);
  endfunction

  function automatic string describe(input srarq_pkg::res_t r);
    return $sformatf("cmd=%0d kind=%0d seq=%0d ack=%0d slot=%0d en=%0b last=%0b",
                     r.command, r.send_kind, r.seq_number, r.ack_number, r.slot,
                     r.network_enable, r.last);
  endfunction

  task automatic reset_link_mirror();
    snd_low = '0;
    snd_next = '0;
    rcv_exp = '0;
    rcv_lim = SW'(srarq_pkg::WINDOW_SLOTS);
    arrived = '0;
    nak_ok = 1'b1;
    phys_rdy = 1'b0;
    buf_count = 0;
  endtask

  // Commands past the per-event limit are dropped, but the state still moves.
  task automatic queue_cmd(input srarq_pkg::cmd_t c, input logic [1:0] kind,
                           input logic [SW-1:0] seq, input logic [SW-1:0] ack,
                           input logic [LW-1:0] slot);
    srarq_pkg::res_t r;
    if (cmds_in_event < srarq_pkg::MAX_CMDS) begin
      r = '{command: c, send_kind: kind, seq_number: seq, ack_number: ack, slot: slot,
            network_enable: 1'b0, last: 1'b0};
      expected_cmds.push_back(r);
    end
    cmds_in_event++;
  endtask

  task automatic issue_frame(input logic [1:0] kind, input logic [SW-1:0] seq,
                             input logic [SW-1:0] ack);
    queue_cmd(srarq_pkg::CMD_SEND, kind, seq, ack,
              (kind == srarq_pkg::KIND_DATA) ? seq[LW-1:0] : '0);
    phys_rdy = 1'b0;
    if (kind == srarq_pkg::KIND_DATA)
      queue_cmd(srarq_pkg::CMD_START_DT, '0, seq, '0, '0);
    else if (kind == srarq_pkg::KIND_NAK)
      nak_ok = 1'b0;
    queue_cmd(srarq_pkg::CMD_STOP_AT, '0, '0, '0, '0);
  endtask

  task automatic take_frame(input link_event_t ev);
    logic [SW-1:0] acked;
    int n;
    if (!ev.good) begin
      if (nak_ok) issue_frame(srarq_pkg::KIND_NAK, rcv_exp, '0);
      return;
    end
    acked = ev.fack;
    if (ev.kind == srarq_pkg::KIND_DATA) begin
      if (ev.fseq != rcv_exp && nak_ok)
        issue_frame(srarq_pkg::KIND_NAK, rcv_exp, '0);
      else
        queue_cmd(srarq_pkg::CMD_START_AT, '0, '0, '0, '0);
      if (seq_between(rcv_exp, ev.fseq, rcv_lim) && !arrived[ev.fseq[LW-1:0]]) begin
        arrived[ev.fseq[LW-1:0]] = 1'b1;
        for (n = 0; n < srarq_pkg::WINDOW_SLOTS && arrived[rcv_exp[LW-1:0]]; n++) begin
          queue_cmd(srarq_pkg::CMD_DELIVER, '0, '0, '0, rcv_exp[LW-1:0]);
          nak_ok = 1'b1;
          arrived[rcv_exp[LW-1:0]] = 1'b0;
          rcv_exp++;
          rcv_lim++;
          queue_cmd(srarq_pkg::CMD_START_AT, '0, '0, '0, '0);
        end
      end
    end else if (ev.kind == srarq_pkg::KIND_NAK) begin
      if (seq_between(snd_low, ev.fseq, snd_next))
        issue_frame(srarq_pkg::KIND_DATA, ev.fseq, rcv_exp - 1'b1);
      return;
    end else if (ev.kind == srarq_pkg::KIND_ACK) begin
      acked = ev.fseq;
    end
    for (n = 0; n <= srarq_pkg::SEQ_MAX && seq_between(snd_low, acked, snd_next); n++) begin
      if (buf_count > 0) buf_count--;
      queue_cmd(srarq_pkg::CMD_STOP_DT, '0, snd_low, '0, '0);
      snd_low++;
    end
  endtask

  task automatic predict_link_commands(input link_event_t ev);
    srarq_pkg::res_t gate;
    cmds_in_event = 0;
    case (ev.op)
      srarq_pkg::OP_NET_READY: begin
        if (buf_count < srarq_pkg::BC_MAX) buf_count++;
        issue_frame(srarq_pkg::KIND_DATA, snd_next, rcv_exp - 1'b1);
        snd_next++;
      end
      srarq_pkg::OP_PHYS_READY: phys_rdy = 1'b1;
      srarq_pkg::OP_FRAME:      take_frame(ev);
      srarq_pkg::OP_DATA_TMO:   issue_frame(srarq_pkg::KIND_DATA, ev.tseq, rcv_exp - 1'b1);
      srarq_pkg::OP_ACK_TMO:    issue_frame(srarq_pkg::KIND_ACK, rcv_exp - 1'b1, '0);
      default: ;
    endcase
    gate = '{command: srarq_pkg::CMD_GATE, send_kind: '0, seq_number: '0, ack_number: '0,
             slot: '0,
             network_enable: (buf_count < srarq_pkg::WINDOW_SLOTS) && phys_rdy,
             last: 1'b1};
    expected_cmds.push_back(gate);
    if (cmds_in_event > srarq_pkg::MAX_CMDS) overflow_events++;
    if (cmds_in_event > longest_event) longest_event = cmds_in_event;
  endtask

  // ------------------------------------------------------------------ stimulus

  function automatic link_event_t make_event(input logic [2:0] op, input logic good,
                                             input logic [1:0] kind,
                                             input logic [SW-1:0] fseq,
                                             input logic [SW-1:0] fack,
                                             input logic [SW-1:0] tseq);
    return '{op: op, good: good, kind: kind, fseq: fseq, fack: fack, tseq: tseq};
  endfunction

  // A sequence number inside the send window, or the one just below it when empty.
  function automatic logic [SW-1:0] pick_outstanding();
    logic [SW-1:0] outstanding;
    outstanding = snd_next - snd_low;
    if (outstanding == 0) return snd_low - 1'b1;
    return SW'(snd_low + $urandom_range(0, outstanding - 1));
  endfunction

  // Mostly a peer that behaves, with random payload; a fifth of the events are noise.
  function automatic link_event_t next_link_event();
    link_event_t ev;
    logic [SW-1:0] outstanding;
    int pick;
    ev.op = 3'($urandom_range(0, 7));
    ev.good = 1'($urandom);
    ev.kind = 2'($urandom);
    ev.fseq = SW'($urandom);
    ev.fack = SW'($urandom);
    ev.tseq = SW'($urandom);
    if ($urandom_range(0, 9) < 2) return ev;
    outstanding = snd_next - snd_low;
    ev.good = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 15 && outstanding < 12) begin
      ev.op = srarq_pkg::OP_NET_READY;
    end else if (pick < 25) begin
      ev.op = srarq_pkg::OP_PHYS_READY;
    end else if (pick < 55) begin
      ev.op = srarq_pkg::OP_FRAME;
      ev.kind = srarq_pkg::KIND_DATA;
      ev.fseq = ($urandom_range(0, 2) == 0) ? rcv_exp :
                SW'(rcv_exp + $urandom_range(1, srarq_pkg::WINDOW_SLOTS - 1));
      ev.fack = pick_outstanding();
    end else if (pick < 67) begin
      ev.op = srarq_pkg::OP_FRAME;
      ev.kind = srarq_pkg::KIND_ACK;
      ev.fseq = pick_outstanding();
    end else if (pick < 75) begin
      ev.op = srarq_pkg::OP_FRAME;
      ev.kind = srarq_pkg::KIND_NAK;
      ev.fseq = pick_outstanding();
    end else if (pick < 83) begin
      ev.op = srarq_pkg::OP_DATA_TMO;
      ev.tseq = pick_outstanding();
    end else if (pick < 92) begin
      ev.op = srarq_pkg::OP_ACK_TMO;
    end else begin
      ev.op = srarq_pkg::OP_FRAME;
      ev.good = 1'b0;
    end
    return ev;
  endfunction

  // Offers one event in bursts separated by random gaps and waits for its transfer.
  task automatic send_item(input link_event_t ev);
    int gap_cycles;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_cycles > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap_cycles - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_operation <= ev.op;
    in_frame_good <= ev.good;
    in_rx_kind <= ev.kind;
    in_rx_seq <= ev.fseq;
    in_frame_ack <= ev.fack;
    in_timeout_seq <= ev.tseq;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_link_commands(ev);
    burst_left--;
    events_sent++;
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // ---------------------------------------------------------------------- tests

  task automatic test_basic_events();
    send_item(make_event(srarq_pkg::OP_ACK_TMO, 1'b1, srarq_pkg::KIND_DATA, '0, '0, '0));
    send_item(make_event(3'(srarq_pkg::OP_ACK_TMO + 3), 1'b1, KIND_UNKNOWN, '1, '1, '1));
    send_item(make_event(srarq_pkg::OP_FRAME, 1'b0, KIND_UNKNOWN, '1, '1, '1));
    // The second bad frame finds the NAK already spent for this gap.
    send_item(make_event(srarq_pkg::OP_FRAME, 1'b0, srarq_pkg::KIND_DATA, '0, '0, '0));
    send_item(make_event(srarq_pkg::OP_DATA_TMO, 1'b0, srarq_pkg::KIND_DATA, '0, '0, '1));
  endtask

  // Fills the send window and parks seven frames out of order, so that the in-order
  // frame walks a full delivery run and a full ack run and overflows the command limit.
  task automatic test_command_overflow();
    int k;
    send_item(make_event(srarq_pkg::OP_PHYS_READY, 1'b1, srarq_pkg::KIND_DATA, '0, '0, '0));
    send_item(make_event(srarq_pkg::OP_NET_READY, 1'b1, srarq_pkg::KIND_DATA, '0, '0, '0));
    send_item(make_event(srarq_pkg::OP_NET_READY, 1'b0, srarq_pkg::KIND_NAK, '1, '1, '1));
    send_item(make_event(srarq_pkg::OP_FRAME, 1'b1, KIND_UNKNOWN, '0, snd_low, '0));
    send_item(make_event(srarq_pkg::OP_FRAME, 1'b1, srarq_pkg::KIND_NAK, snd_low, '0, '0));
    while (SW'(snd_next - snd_low) != SW'(srarq_pkg::SEQ_MAX))
      send_item(make_event(srarq_pkg::OP_NET_READY, 1'b1, srarq_pkg::KIND_DATA,
                           '0, '0, '0));
    for (k = srarq_pkg::WINDOW_SLOTS - 1; k >= 1; k--)
      send_item(make_event(srarq_pkg::OP_FRAME, 1'b1, srarq_pkg::KIND_DATA,
                           SW'(rcv_exp + k), snd_low - 1'b1, '0));
    send_item(make_event(srarq_pkg::OP_FRAME, 1'b1, srarq_pkg::KIND_DATA, rcv_exp,
                         snd_next - 1'b1, '0));
  endtask

  task automatic test_receiver_hold();
    @(posedge clk);
    hold_cycles = HOLD_CYCLES;
    repeat (30) send_item(next_link_event());
  endtask

  task automatic test_drain_pause();
    repeat (20) send_item(next_link_event());
    pause_until_drained();
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_item(next_link_event());
  endtask

  // ------------------------------------------------------------ result checking

  always @(posedge clk) begin
    srarq_pkg::res_t got;
    srarq_pkg::res_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got = '{command: srarq_pkg::cmd_t'(out_command), send_kind: out_send_kind,
              seq_number: out_seq_number, ack_number: out_ack_number, slot: out_slot,
              network_enable: out_network_enable, last: out_last};
      cmds_checked++;
      if (expected_cmds.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("[%0t] unexpected command: %s", $time, describe(got));
      end else begin
        want = expected_cmds.pop_front();
        if (got.command !== want.command || got.send_kind !== want.send_kind ||
            got.seq_number !== want.seq_number || got.ack_number !== want.ack_number ||
            got.slot !== want.slot || got.network_enable !== want.network_enable ||
            got.last !== want.last) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("[%0t] mismatch: expected %s, got %s", $time, describe(want),
                     describe(got));
        end
      end
    end
  end

  // Receiver stall pattern; a requested hold-off overrides it for a counted stretch.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end
      mode_left = mode_left - 1;
      stall_phase = stall_phase + 1;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_PERIODIC: out_stall <= (stall_phase % 5 < 2);
        default:        out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d commands outstanding", cycle_count,
               expected_cmds.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    reset_link_mirror();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_basic_events();
    test_command_overflow();
    test_receiver_hold();
    test_drain_pause();
    test_random_traffic(230);

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d link events and %0d commands; %0d events overflowed the limit,",
             events_sent, cmds_checked, overflow_events);
    $display("the busiest event produced %0d commands before truncation.", longest_event);
    if (error_count == 0 && expected_cmds.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d failures, %0d commands never seen", error_count, expected_cmds.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
